// ===== rtl/dtti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_pkg: shared types, widths and tables of the drift time interpolator
// Holds the distance and time tables of both gases and the stage payload types.
// ----------------------------------------------------------------------------
package dtti_pkg;

    localparam int TABLE_POINTS = 42;
    localparam int SEG_W        = $clog2(TABLE_POINTS);
    localparam int THERM_W      = TABLE_POINTS - 2;

    localparam int DIST_W  = 15;   // table and input distances, 1/16 um
    localparam int TIME_W  = 23;   // table times, 1e-5 ns
    localparam int SPAN_W  = 10;   // longest segment is 800
    localparam int TD_W    = 18;   // largest time step along a segment
    localparam int DD_W    = DIST_W;
    localparam int P_W     = TIME_W + SPAN_W;
    localparam int NUM_W   = P_W + 1;

    // time in 1/1024 ns = (num*64 + span*3125) / (span*6250), exact floor
    localparam int FRAC_SHIFT = 6;
    localparam int SPAN_SCALE = 3125;
    localparam int SPANC_W    = 22;
    localparam int DEN_W      = SPANC_W + 1;
    localparam int REM_W      = NUM_W + FRAC_SHIFT + 1;

    localparam int Q_W        = 16;
    localparam int DIV_STAGES = Q_W + 1;

    localparam logic [DIST_W-1:0] DIST_TAB [2][TABLE_POINTS] = '{
        '{ 248, 552, 1352, 2152, 2952, 3752, 4552, 5352, 6152, 6952,
           7752, 8552, 9352, 10152, 10952, 11752, 12552, 13352, 14152, 14952,
           15752, 16552, 17352, 18152, 18952, 19752, 20552, 21352, 22152, 22952,
           23752, 24552, 25352, 26152, 26952, 27752, 28552, 29352, 30152, 30952,
           31736, 32000 },
        '{ 248, 560, 1360, 2160, 2960, 3760, 4560, 5360, 6160, 6960,
           7760, 8560, 9360, 10160, 10960, 11760, 12560, 13360, 14160, 14960,
           15760, 16560, 17360, 18160, 18960, 19760, 20560, 21360, 22160, 22960,
           23760, 24560, 25360, 26160, 26960, 27760, 28560, 29360, 30160, 30960,
           31760, 32000 }
    };

    // [gas][field select][point]
    localparam logic [TIME_W-1:0] TIME_TAB [2][2][TABLE_POINTS] = '{
        '{
            '{ 0, 18332, 69730, 142695, 228892, 322042, 420607, 520461, 623645,
               727117, 833306, 939640, 1046440, 1152810, 1259370, 1364130, 1468120,
               1571150, 1675140, 1775960, 1876260, 1975830, 2073020, 2170100,
               2268170, 2366250, 2461820, 2562920, 2661640, 2761150, 2864840,
               2969290, 3076020, 3184830, 3296230, 3410290, 3528880, 3646400,
               3771070, 3898610, 4021950, 4060410 },
            '{ 0, 18464, 70001, 143068, 229603, 322918, 422207, 524324, 628913,
               734263, 841839, 950610, 1061570, 1172250, 1282830, 1393490, 1502640,
               1613370, 1723240, 1834400, 1943280, 2052850, 2163350, 2273240,
               2387280, 2500180, 2615160, 2731030, 2850970, 2973110, 3093930,
               3222650, 3355120, 3489220, 3624410, 3765310, 3912840, 4059230,
               4211830, 4366980, 4520380, 4570890 }
        },
        '{
            '{ 0, 6111, 36046, 80805, 134902, 194331, 256331, 319340, 382862,
               446891, 511496, 576497, 643076, 710696, 779338, 849140, 919973,
               991731, 1064250, 1139280, 1211520, 1286580, 1361880, 1437620,
               1513880, 1590680, 1667960, 1745910, 1823890, 1902660, 1982410,
               2062470, 2143880, 2228400, 2309180, 2409970, 2479110, 2566320,
               2654350, 2744470, 2800500, 2880410 },
            '{ 0, 6122, 36227, 81371, 136128, 196498, 259837, 324738, 390668,
               457660, 526812, 595973, 667857, 742868, 816936, 894547, 974109,
               1055550, 1138840, 1224000, 1310950, 1400600, 1490150, 1583390,
               1676960, 1773400, 1872040, 1973030, 2076490, 2182530, 2291240,
               2402780, 2517370, 2640410, 2756190, 2880590, 3008980, 3139850,
               3274880, 3413650, 3500500, 3598500 }
        }
    };

    typedef struct packed {
        logic valid;
        logic at_wire;
    } t_ctl;

    typedef struct packed {
        logic [DD_W-1:0]   dd;
        logic [SPAN_W-1:0] span;
        logic [TIME_W-1:0] tl;
        logic [TD_W-1:0]   td;
    } t_seg;

    typedef struct packed {
        logic [REM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_frac;

endpackage

// ===== rtl/drift_time_table_interpolator.sv =====
`timescale 1ns / 1ps
// pipeline: 23 register stages (3 search, 2 product, 17 divider, 1 output)
// throughput: one beat per cycle; the whole pipeline holds while the output stalls
// reset: synchronous, clears all valid bits and sets the gas register to xenon
// ----------------------------------------------------------------------------
// drift_time_table_interpolator: distance to drift time by table interpolation
// Picks the segment of the selected table, interpolates, rounds and saturates the time.
// ----------------------------------------------------------------------------
module drift_time_table_interpolator
    import dtti_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,   // gas_is_argon
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,     // [14:0] distance, [15] zero fill
    input  logic        i_s_tuser,     // [0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,     // [15:0] drift_time
    output logic        o_m_tuser      // [0] at_wire
);

    logic           r_gas;
    logic           w_en;
    t_ctl           w_seg_ctl;
    t_seg           w_seg;
    t_ctl           w_frac_ctl;
    t_frac          w_frac;
    t_ctl           w_div_ctl;
    logic [Q_W-1:0] w_quot;
    logic           w_ovf;
    logic [Q_W-1:0] n_drift_time;

    logic           r_out_valid;
    logic [Q_W-1:0] r_drift_time;
    logic           r_at_wire;

    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas <= 1'b0;
        end else if (i_cfg_we) begin
            r_gas <= i_cfg_wdata;
        end
    end

    dtti_seg u_seg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_s_tvalid),
        .i_distance (i_s_tdata[DIST_W-1:0]),
        .i_opcode   (i_s_tuser),
        .i_gas      (r_gas),
        .o_ctl      (w_seg_ctl),
        .o_seg      (w_seg)
    );

    dtti_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_seg_ctl),
        .i_seg   (w_seg),
        .o_ctl   (w_frac_ctl),
        .o_frac  (w_frac)
    );

    dtti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_frac_ctl),
        .i_frac  (w_frac),
        .o_ctl   (w_div_ctl),
        .o_quot  (w_quot),
        .o_ovf   (w_ovf)
    );

    always_comb begin
        priority if (w_div_ctl.at_wire) begin
            n_drift_time = '0;
        end else if (w_ovf) begin
            n_drift_time = '1;
        end else begin
            n_drift_time = w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_drift_time <= n_drift_time;
            r_at_wire    <= w_div_ctl.at_wire;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_drift_time;
    assign o_m_tuser  = r_at_wire;

    // a hit at the wire always reads as zero time
    a_wire_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("at_wire beat with nonzero drift time");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

    // input side stalls only while the output register holds a beat that is not taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without a blocked output beat");

endmodule

// ===== rtl/dtti_seg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_seg: segment search and table fetch
// Three stages: compare against the table points, encode the segment, read its ends.
// ----------------------------------------------------------------------------
module dtti_seg
    import dtti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DIST_W-1:0] i_distance,
    input  logic              i_opcode,
    input  logic              i_gas,
    output t_ctl              o_ctl,
    output t_seg              o_seg
);

    logic [THERM_W-1:0] n_therm;
    logic               n_at_wire;
    logic [SEG_W-1:0]   n_lo;
    logic [SEG_W-1:0]   w_hi;
    logic [DIST_W-1:0]  w_dl;
    logic [DIST_W-1:0]  w_dh;
    logic [TIME_W-1:0]  w_tl;
    logic [TIME_W-1:0]  w_th;
    t_seg               n_seg;

    t_ctl               r1_ctl;
    logic [THERM_W-1:0] r1_therm;
    logic [DIST_W-1:0]  r1_distance;
    logic               r1_opcode;
    logic               r1_gas;

    t_ctl               r2_ctl;
    logic [SEG_W-1:0]   r2_lo;
    logic [DIST_W-1:0]  r2_distance;
    logic               r2_opcode;
    logic               r2_gas;

    t_ctl               r3_ctl;
    t_seg               r3_seg;

    // thermometer code of the inner points at or below the distance
    always_comb begin
        for (int i = 1; i <= TABLE_POINTS - 2; i++) begin
            n_therm[i-1] = (DIST_TAB[i_gas][i] <= i_distance);
        end
        n_at_wire = (i_distance <= DIST_TAB[i_gas][0]);
    end

    always_comb begin
        n_lo = '0;
        for (int i = 0; i < THERM_W; i++) begin
            n_lo = n_lo + SEG_W'(r1_therm[i]);
        end
    end

    assign w_hi = r2_lo + SEG_W'(1);
    assign w_dl = DIST_TAB[r2_gas][r2_lo];
    assign w_dh = DIST_TAB[r2_gas][w_hi];
    assign w_tl = TIME_TAB[r2_gas][r2_opcode][r2_lo];
    assign w_th = TIME_TAB[r2_gas][r2_opcode][w_hi];

    always_comb begin
        n_seg.dd   = DD_W'(r2_distance - w_dl);
        n_seg.span = SPAN_W'(w_dh - w_dl);
        n_seg.tl   = w_tl;
        n_seg.td   = TD_W'(w_th - w_tl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= '{valid: i_valid, at_wire: n_at_wire};
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_therm    <= n_therm;
            r1_distance <= i_distance;
            r1_opcode   <= i_opcode;
            r1_gas      <= i_gas;
            r2_lo       <= n_lo;
            r2_distance <= r1_distance;
            r2_opcode   <= r1_opcode;
            r2_gas      <= r1_gas;
            r3_seg      <= n_seg;
        end
    end

    assign o_ctl = r3_ctl;
    assign o_seg = r3_seg;

endmodule

// ===== rtl/dtti_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_interp: interpolation products and rounded fraction
// Two stages: the three products, then the scaled numerator and denominator.
// ----------------------------------------------------------------------------
module dtti_interp
    import dtti_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_ctl  i_ctl,
    input  t_seg  i_seg,
    output t_ctl  o_ctl,
    output t_frac o_frac
);

    t_ctl               r4_ctl;
    logic [P_W-1:0]     r4_p1;
    logic [P_W-1:0]     r4_p2;
    logic [SPANC_W-1:0] r4_spanc;

    t_ctl               r5_ctl;
    t_frac              r5_frac;

    logic [NUM_W-1:0]   w_num;

    // tl*span + (th-tl)*(d-dl)
    assign w_num = NUM_W'(r4_p1) + NUM_W'(r4_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
            r5_ctl <= '0;
        end else if (i_en) begin
            r4_ctl <= i_ctl;
            r5_ctl <= r4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_p1        <= P_W'(i_seg.tl) * P_W'(i_seg.span);
            r4_p2        <= P_W'(i_seg.td) * P_W'(i_seg.dd);
            r4_spanc     <= SPANC_W'(i_seg.span) * SPANC_W'(SPAN_SCALE);
            // half the divisor is added for round half up
            r5_frac.num  <= REM_W'({w_num, FRAC_SHIFT'(0)}) + REM_W'(r4_spanc);
            r5_frac.den  <= {r4_spanc, 1'b0};
        end
    end

    assign o_ctl  = r5_ctl;
    assign o_frac = r5_frac;

endmodule

// ===== rtl/dtti_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_div: pipelined restoring divider
// One quotient bit per stage; the first stage only flags a quotient too large.
// ----------------------------------------------------------------------------
module dtti_div
    import dtti_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  t_ctl           i_ctl,
    input  t_frac          i_frac,
    output t_ctl           o_ctl,
    output logic [Q_W-1:0] o_quot,
    output logic           o_ovf
);

    t_ctl             w_ctl [DIV_STAGES+1];
    logic [REM_W-1:0] w_rem [DIV_STAGES+1];
    logic [DEN_W-1:0] w_den [DIV_STAGES+1];
    logic [Q_W-1:0]   w_quot[DIV_STAGES+1];
    logic             w_ovf [DIV_STAGES+1];

    assign w_ctl[0]  = i_ctl;
    assign w_rem[0]  = i_frac.num;
    assign w_den[0]  = i_frac.den;
    assign w_quot[0] = '0;
    assign w_ovf[0]  = 1'b0;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        t_ctl             r_ctl;
        logic [REM_W-1:0] r_rem;
        logic [DEN_W-1:0] r_den;
        logic [Q_W-1:0]   r_quot;
        logic             r_ovf;
        logic [REM_W-1:0] n_rem;
        logic [Q_W-1:0]   n_quot;
        logic             n_ovf;
        logic [REM_W-1:0] w_sub;
        logic             w_ge;

        assign w_sub = REM_W'(w_den[g]) << (Q_W - g);
        assign w_ge  = (w_rem[g] >= w_sub);

        if (g == 0) begin : g_range
            // quotient would need more than Q_W bits
            always_comb begin
                n_rem  = w_rem[g];
                n_quot = w_quot[g];
                n_ovf  = w_ge;
            end
        end else begin : g_bit
            always_comb begin
                n_rem             = w_ge ? (w_rem[g] - w_sub) : w_rem[g];
                n_quot            = w_quot[g];
                n_quot[Q_W - g]   = w_ge;
                n_ovf             = w_ovf[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else if (i_en) begin
                r_ctl <= w_ctl[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_den  <= w_den[g];
                r_quot <= n_quot;
                r_ovf  <= n_ovf;
            end
        end

        assign w_ctl[g+1]  = r_ctl;
        assign w_rem[g+1]  = r_rem;
        assign w_den[g+1]  = r_den;
        assign w_quot[g+1] = r_quot;
        assign w_ovf[g+1]  = r_ovf;
    end

    assign o_ctl  = w_ctl[DIV_STAGES];
    assign o_quot = w_quot[DIV_STAGES];
    assign o_ovf  = w_ovf[DIV_STAGES];

endmodule

// ===== tb/drift_time_table_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drift_time_table_interpolator_tb: self-checking bench for the drift time table
// Streams distances under both gas settings, predicts each drift time by exact
// rational interpolation of private table copies and compares every output beat.
// ----------------------------------------------------------------------------
module drift_time_table_interpolator_tb;

    localparam int N_POINTS        = 42;
    localparam int STALL_LIMIT     = 4000;
    localparam int PRESSURE_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 30;
    localparam int MAX_REPORTS     = 10;
    localparam logic GAS_XENON     = 1'b0;
    localparam logic GAS_ARGON     = 1'b1;
    localparam logic OP_NO_FIELD   = 1'b0;
    localparam logic OP_MAX_FIELD  = 1'b1;

    // distances in 1/16 um, [gas][point]
    localparam int DIST_PTS [2][N_POINTS] = '{
        '{ 248, 552, 1352, 2152, 2952, 3752, 4552, 5352, 6152, 6952,
           7752, 8552, 9352, 10152, 10952, 11752, 12552, 13352, 14152, 14952,
           15752, 16552, 17352, 18152, 18952, 19752, 20552, 21352, 22152, 22952,
           23752, 24552, 25352, 26152, 26952, 27752, 28552, 29352, 30152, 30952,
           31736, 32000 },
        '{ 248, 560, 1360, 2160, 2960, 3760, 4560, 5360, 6160, 6960,
           7760, 8560, 9360, 10160, 10960, 11760, 12560, 13360, 14160, 14960,
           15760, 16560, 17360, 18160, 18960, 19760, 20560, 21360, 22160, 22960,
           23760, 24560, 25360, 26160, 26960, 27760, 28560, 29360, 30160, 30960,
           31760, 32000 }
    };

    // times in 1e-5 ns, [gas][field][point]
    localparam int TIME_PTS [2][2][N_POINTS] = '{
        '{
            '{ 0, 18332, 69730, 142695, 228892, 322042, 420607, 520461, 623645,
               727117, 833306, 939640, 1046440, 1152810, 1259370, 1364130, 1468120,
               1571150, 1675140, 1775960, 1876260, 1975830, 2073020, 2170100,
               2268170, 2366250, 2461820, 2562920, 2661640, 2761150, 2864840,
               2969290, 3076020, 3184830, 3296230, 3410290, 3528880, 3646400,
               3771070, 3898610, 4021950, 4060410 },
            '{ 0, 18464, 70001, 143068, 229603, 322918, 422207, 524324, 628913,
               734263, 841839, 950610, 1061570, 1172250, 1282830, 1393490, 1502640,
               1613370, 1723240, 1834400, 1943280, 2052850, 2163350, 2273240,
               2387280, 2500180, 2615160, 2731030, 2850970, 2973110, 3093930,
               3222650, 3355120, 3489220, 3624410, 3765310, 3912840, 4059230,
               4211830, 4366980, 4520380, 4570890 }
        },
        '{
            '{ 0, 6111, 36046, 80805, 134902, 194331, 256331, 319340, 382862,
               446891, 511496, 576497, 643076, 710696, 779338, 849140, 919973,
               991731, 1064250, 1139280, 1211520, 1286580, 1361880, 1437620,
               1513880, 1590680, 1667960, 1745910, 1823890, 1902660, 1982410,
               2062470, 2143880, 2228400, 2309180, 2409970, 2479110, 2566320,
               2654350, 2744470, 2800500, 2880410 },
            '{ 0, 6122, 36227, 81371, 136128, 196498, 259837, 324738, 390668,
               457660, 526812, 595973, 667857, 742868, 816936, 894547, 974109,
               1055550, 1138840, 1224000, 1310950, 1400600, 1490150, 1583390,
               1676960, 1773400, 1872040, 1973030, 2076490, 2182530, 2291240,
               2402780, 2517370, 2640410, 2756190, 2880590, 3008980, 3139850,
               3274880, 3413650, 3500500, 3598500 }
        }
    };

    typedef struct packed {
        logic [15:0] drift_time;
        logic        at_wire;
    } t_drift_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;    // [14:0] distance, [15] zero fill
    logic        i_s_tuser;    // [0] opcode
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;    // [15:0] drift_time
    logic        o_m_tuser;    // [0] at_wire

    logic gas_argon;
    bit   steady;
    bit   pressure_done;
    int   n_accepted_in;
    int   stall_cycles;

    drift_time_table_interpolator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // exact interpolation, rounded half up to 1/1024 ns and clamped
    function automatic t_drift_res predict_drift(logic argon, logic op,
                                                 logic [14:0] dist_val);
        t_drift_res res;
        int         hi;
        bit         found;
        longint     d, dl, dh, tl, th, span, num, den, q;
        res.drift_time = '0;
        res.at_wire    = 1'b0;
        d = longint'(dist_val);
        if (d <= DIST_PTS[argon][0]) begin
            res.at_wire = 1'b1;
            return res;
        end
        hi    = N_POINTS - 1;
        found = 1'b0;
        for (int i = 0; i < N_POINTS - 1; i++) begin
            if (!found && DIST_PTS[argon][i] > d) begin
                hi    = i;
                found = 1'b1;
            end
        end
        dl   = DIST_PTS[argon][hi-1];
        dh   = DIST_PTS[argon][hi];
        tl   = TIME_PTS[argon][op][hi-1];
        th   = TIME_PTS[argon][op][hi];
        span = dh - dl;
        if (span <= 0) begin
            num = tl;
            den = 100000;
        end else begin
            num = tl * span + (th - tl) * (d - dl);
            den = span * 100000;
        end
        if (num <= 0)
            q = 0;
        else
            q = (num * 1024 + den / 2) / den;
        if (q > 65535)
            q = 65535;
        res.drift_time = q[15:0];
        return res;
    endfunction

    class drift_scoreboard;
        t_drift_res expected_q[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function void note_input(logic argon, logic op, logic [14:0] dist_val);
            t_drift_res exp_res;
            exp_res = predict_drift(argon, op, dist_val);
            expected_q.insert(expected_q.size(), exp_res);
        endfunction

        function void check_result(logic [15:0] drift_time, logic at_wire);
            t_drift_res exp_res;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected beat: drift_time %0d at_wire %0d",
                             drift_time, at_wire);
                return;
            end
            exp_res = expected_q.pop_front();
            if (exp_res.drift_time !== drift_time || exp_res.at_wire !== at_wire) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: drift_time exp %0d got %0d, at_wire exp %0d got %0d",
                             exp_res.drift_time, drift_time, exp_res.at_wire, at_wire);
            end
        endfunction
    endclass

    drift_scoreboard sb;

    // output monitor and no-progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser);
        if (i_rst_n && ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls plus one long hold-off to back up the pipeline
    initial begin
        int n;
        int r;
        i_m_tready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!pressure_done && n_accepted_in >= 40) begin
                i_m_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
                pressure_done = 1'b1;
            end else if (steady) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_m_tready <= 1'b1;
                    n = $urandom_range(1, 20);
                end else begin
                    i_m_tready <= 1'b0;
                    n = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(int dist_val, logic op);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, dist_val[14:0]};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(gas_argon, op, dist_val[14:0]);
        n_accepted_in++;
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_gas(logic argon);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= argon;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        gas_argon = argon;
    endtask

    // wire edge, table points, extrapolation and the top of the range
    task automatic run_directed();
        send_item(0, OP_NO_FIELD);
        send_item(DIST_PTS[gas_argon][0], OP_MAX_FIELD);
        send_item(DIST_PTS[gas_argon][0] + 1, OP_NO_FIELD);
        send_item(DIST_PTS[gas_argon][1], OP_MAX_FIELD);
        send_item(DIST_PTS[gas_argon][1] + 1, OP_NO_FIELD);
        send_item(DIST_PTS[gas_argon][N_POINTS-2], OP_MAX_FIELD);
        send_item(DIST_PTS[gas_argon][N_POINTS-1] - 1, OP_NO_FIELD);
        send_item(DIST_PTS[gas_argon][N_POINTS-1], OP_MAX_FIELD);
        send_item(32767, OP_NO_FIELD);
        send_item(32767, OP_MAX_FIELD);
        send_item(21845, OP_NO_FIELD);
        send_item(10922, OP_MAX_FIELD);
    endtask

    task automatic run_random(int count);
        int r;
        int dist_val;
        for (int k = 0; k < count; k++) begin
            steady = (k >= count / 3) && (k < count / 2);
            r = $urandom_range(0, 99);
            if (r < 50) begin
                dist_val = $urandom_range(0, 32767);
            end else if (r < 75) begin
                dist_val = DIST_PTS[gas_argon][$urandom_range(0, N_POINTS - 1)]
                           + $urandom_range(0, 6) - 3;
            end else if (r < 85) begin
                dist_val = $urandom_range(0, 300);
            end else begin
                dist_val = $urandom_range(31700, 32767);
            end
            if (dist_val < 0)
                dist_val = 0;
            if (dist_val > 32767)
                dist_val = 32767;
            send_item(dist_val, logic'($urandom_range(0, 1)));
        end
        steady = 1'b0;
    endtask

    initial begin
        sb = new();
        gas_argon     = GAS_XENON;
        steady        = 1'b0;
        pressure_done = 1'b0;
        n_accepted_in = 0;
        stall_cycles  = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value selects xenon
        run_directed();
        run_random(120);
        write_gas(GAS_ARGON);
        run_directed();
        run_random(130);
        write_gas(GAS_XENON);
        run_random(80);
        write_gas(GAS_ARGON);
        run_random(70);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.errors += sb.expected_q.size();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dtti_pkg.sv
rtl/dtti_seg.sv
rtl/dtti_interp.sv
rtl/dtti_div.sv
rtl/drift_time_table_interpolator.sv
tb/drift_time_table_interpolator_tb.sv
